// ===== rtl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int DEF_BLOCKS    = 65536;
    localparam int DEF_WORD_BITS = 64;

    localparam logic [16:0] BLK_LIMIT_RST = 17'd65536;

    // request op codes
    typedef enum logic [2:0] {
        OP_QUERY    = 3'd0,
        OP_MARK     = 3'd1,
        OP_ALLOC1   = 3'd2,
        OP_ALLOCRUN = 3'd3,
        OP_MARKRUN  = 3'd4,
        OP_COUNT    = 3'd5
    } op_t;

    // controller -> datapath strobes
    typedef struct packed {
        logic clr;    // write zero word, step address
        logic load;   // capture item
        logic eval;   // evaluate current word
        logic bstep;  // evaluate one bit of a mixed word
        logic mrk;    // set up marking of a found run
        logic inc;    // next word
        logic out;    // load result register
    } cmd_t;

    // datapath -> controller status
    typedef struct packed {
        op_t  op;
        logic clr_last;
        logic empty_scan;
        logic len_zero;
        logic mr_none;
        logic hit1;
        logic all_free;
        logic none_free;
        logic run_hit_word;
        logic bit_hit;
        logic bit_last;
        logic last;
        logic mr_last;
    } stat_t;

endpackage

// ===== rtl/bba_if.sv =====
// ----------------------------------------------------------------------------
// bba_req_if / bba_rsp_if
// Valid/ready channels for allocator requests and results.
// ----------------------------------------------------------------------------
interface bba_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [15:0] block_index;
    logic [16:0] run_length;
    logic        mark_used;

    modport source (output valid, op, block_index, run_length, mark_used, input ready);
    modport sink   (input valid, op, block_index, run_length, mark_used, output ready);
endinterface

interface bba_rsp_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic        is_used;
    logic [15:0] found_index;
    logic [16:0] free_count;

    modport source (output valid, status, is_used, found_index, free_count, input ready);
    modport sink   (input valid, status, is_used, found_index, free_count, output ready);
endinterface

// ===== rtl/bba_ram.sv =====
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: clearing pass, word scan, bit walk, run marking, result hand-off.
// ----------------------------------------------------------------------------
module bba_ctrl
    import bba_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t st,
    output cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_RD,
        S_EVAL,
        S_BIT,
        S_MRK,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // next state and strobes
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (st.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                case (st.op)
                    OP_QUERY, OP_MARK:    state_next = S_EVAL;
                    OP_ALLOC1, OP_COUNT:  state_next = st.empty_scan ? S_FIN : S_EVAL;
                    OP_ALLOCRUN:
                        state_next = (st.len_zero || st.empty_scan) ? S_FIN : S_EVAL;
                    OP_MARKRUN:           state_next = st.mr_none ? S_FIN : S_EVAL;
                    default:              state_next = S_FIN;
                endcase
            end
            S_RD:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.eval = 1'b1;
                case (st.op)
                    OP_ALLOC1:
                    begin
                        if (st.hit1 || st.last)
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            cmd.inc    = 1'b1;
                            state_next = S_RD;
                        end
                    end
                    OP_COUNT:
                    begin
                        if (st.last)
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            cmd.inc    = 1'b1;
                            state_next = S_RD;
                        end
                    end
                    OP_ALLOCRUN:
                    begin
                        if (st.all_free && st.run_hit_word)
                        begin
                            state_next = S_MRK;
                        end
                        else if (st.all_free || st.none_free)
                        begin
                            if (st.last)
                            begin
                                state_next = S_FIN;
                            end
                            else
                            begin
                                cmd.inc    = 1'b1;
                                state_next = S_RD;
                            end
                        end
                        else
                        begin
                            state_next = S_BIT;
                        end
                    end
                    OP_MARKRUN:
                    begin
                        if (st.mr_last)
                        begin
                            state_next = S_FIN;
                        end
                        else
                        begin
                            cmd.inc    = 1'b1;
                            state_next = S_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_BIT:
            begin
                cmd.bstep = 1'b1;
                if (st.bit_hit)
                begin
                    state_next = S_MRK;
                end
                else if (st.bit_last)
                begin
                    if (st.last)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cmd.inc    = 1'b1;
                        state_next = S_RD;
                    end
                end
            end
            S_MRK:
            begin
                cmd.mrk    = 1'b1;
                state_next = S_RD;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result valid: set on load, cleared when taken
    always_comb
    begin
        if (cmd.out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/bba_dp.sv =====
// ----------------------------------------------------------------------------
// bba_dp
// Datapath: map RAM, word evaluation, run tracking, counters, result register.
// ----------------------------------------------------------------------------
module bba_dp
    import bba_pkg::*;
#(
    parameter int BLOCKS    = DEF_BLOCKS,
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output stat_t       st,
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata,
    input  logic [2:0]  in_op,
    input  logic [15:0] in_block_index,
    input  logic [16:0] in_run_length,
    input  logic        in_mark_used,
    output logic        out_status,
    output logic        out_is_used,
    output logic [15:0] out_found_index,
    output logic [16:0] out_free_count
);

    localparam int W     = WORD_BITS;
    localparam int WORDS = BLOCKS / WORD_BITS;
    localparam int BW    = $clog2(WORD_BITS);
    localparam int PW    = $clog2(BLOCKS);
    localparam int AW    = PW - BW;
    localparam int PPW   = PW + 1;
    localparam int EW    = ((PPW > 17) ? PPW : 17) + 1;

    localparam logic [EW-1:0] BLOCKS_E = EW'(BLOCKS);
    localparam logic [W-1:0]  ONES     = {W{1'b1}};

    // registers
    logic [16:0]    tb_reg;
    op_t            op_reg;
    logic [PPW-1:0] pos_reg, endm1_reg, lim_reg, run_reg, start_reg, cnt_reg, found_reg;
    logic [AW:0]    addr_reg, limw_reg;
    logic [BW-1:0]  bptr_reg;
    logic [16:0]    len_reg;
    logic           mark_reg, pos_ok_reg, mr_none_reg;
    logic           stat_reg, used_reg;
    logic           o_status_reg, o_used_reg;
    logic [15:0]    o_found_reg;
    logic [16:0]    o_count_reg;

    logic [W-1:0]   rdata, wdata, vmask, fmask, low1, rmask;
    logic           we;
    logic [BW-1:0]  enc, lo, hi;
    logic [BW:0]    pcnt;
    logic [PPW-1:0] word_pos, cur_pos;
    logic [EW-1:0]  idx_e, len_e, tb_e, lim_e, end_e;

    bba_ram #(.WIDTH(W), .DEPTH(WORDS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (addr_reg[AW-1:0]),
        .wdata (wdata),
        .raddr (addr_reg[AW-1:0]),
        .rdata (rdata)
    );

    // load-time arithmetic
    always_comb
    begin
        idx_e = EW'(in_block_index);
        len_e = EW'(in_run_length);
        tb_e  = EW'(tb_reg);
        lim_e = (tb_e < BLOCKS_E) ? tb_e : BLOCKS_E;
        end_e = idx_e + len_e;
        if (end_e > BLOCKS_E)
        begin
            end_e = BLOCKS_E;
        end
    end

    // free mask of the current word, limited to the scan range
    always_comb
    begin
        for (int i = 0; i < W; i++)
        begin
            if (addr_reg < lim_reg[PPW-1:BW])
            begin
                vmask[i] = 1'b1;
            end
            else if (addr_reg == lim_reg[PPW-1:BW])
            begin
                vmask[i] = (BW'(i) < lim_reg[BW-1:0]);
            end
            else
            begin
                vmask[i] = 1'b0;
            end
        end
        fmask = ~rdata & vmask;
        low1  = fmask & (~fmask + 1'b1);
        enc   = '0;
        pcnt  = '0;
        for (int i = 0; i < W; i++)
        begin
            if (low1[i])
            begin
                enc = enc | BW'(i);
            end
            pcnt = pcnt + (BW+1)'(fmask[i]);
        end
    end

    // run mask for mark run
    always_comb
    begin
        lo    = (addr_reg == pos_reg[PPW-1:BW]) ? pos_reg[BW-1:0] : '0;
        hi    = (addr_reg == endm1_reg[PPW-1:BW]) ? endm1_reg[BW-1:0] : BW'(W - 1);
        rmask = (ONES << lo) & (ONES >> (BW'(W - 1) - hi));
    end

    assign word_pos = PPW'({addr_reg[AW-1:0], {BW{1'b0}}});
    assign cur_pos  = PPW'({addr_reg[AW-1:0], bptr_reg});

    // map write
    always_comb
    begin
        we    = 1'b0;
        wdata = rdata;
        if (cmd.clr)
        begin
            we    = 1'b1;
            wdata = '0;
        end
        else if (cmd.eval)
        begin
            case (op_reg)
                OP_MARK:
                begin
                    we = pos_ok_reg;
                    wdata[pos_reg[BW-1:0]] = mark_reg;
                end
                OP_ALLOC1:
                begin
                    we    = (fmask != '0);
                    wdata = rdata | low1;
                end
                OP_MARKRUN:
                begin
                    we    = 1'b1;
                    wdata = mark_reg ? (rdata | rmask) : (rdata & ~rmask);
                end
                default:
                begin
                    we = 1'b0;
                end
            endcase
        end
    end

    // status
    always_comb
    begin
        st.op           = op_reg;
        st.clr_last     = (addr_reg == (AW+1)'(WORDS - 1));
        st.empty_scan   = (limw_reg == '0);
        st.len_zero     = (len_reg == '0);
        st.mr_none      = mr_none_reg;
        st.hit1         = (fmask != '0);
        st.all_free     = (fmask == ONES);
        st.none_free    = (fmask == '0);
        st.run_hit_word = ((EW'(run_reg) + EW'(W)) >= EW'(len_reg));
        st.bit_hit      = fmask[bptr_reg] && ((EW'(run_reg) + 1'b1) == EW'(len_reg));
        st.bit_last     = (bptr_reg == BW'(W - 1));
        st.last         = ((addr_reg + 1'b1) == limw_reg);
        st.mr_last      = (addr_reg == endm1_reg[PPW-1:BW]);
    end

    // configuration register and scan address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tb_reg   <= BLK_LIMIT_RST;
            addr_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                tb_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                addr_reg <= (in_op inside {OP_QUERY, OP_MARK, OP_MARKRUN})
                            ? idx_e[PPW-1:BW] : '0;
            end
            else if (cmd.mrk)
            begin
                addr_reg <= found_reg[PPW-1:BW];
            end
            else if (cmd.clr || cmd.inc)
            begin
                addr_reg <= addr_reg + 1'b1;
            end
        end
    end

    // item registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg      <= op_t'(in_op);
            pos_ok_reg  <= (idx_e < BLOCKS_E);
            pos_reg     <= (idx_e < BLOCKS_E) ? idx_e[PPW-1:0] : '0;
            len_reg     <= in_run_length;
            mark_reg    <= in_mark_used;
            mr_none_reg <= (in_run_length == '0) || (idx_e >= BLOCKS_E);
            endm1_reg   <= PPW'(end_e - 1'b1);
            lim_reg     <= lim_e[PPW-1:0];
            limw_reg    <= (AW+1)'((lim_e + EW'(W - 1)) >> BW);
            stat_reg    <= in_op inside {OP_ALLOC1, OP_ALLOCRUN};
            used_reg    <= 1'b0;
            found_reg   <= '0;
            cnt_reg     <= '0;
            run_reg     <= '0;
            start_reg   <= '0;
            bptr_reg    <= '0;
        end
        else if (cmd.mrk)
        begin
            op_reg     <= OP_MARKRUN;
            pos_ok_reg <= 1'b1;
            pos_reg    <= found_reg;
            mark_reg   <= 1'b1;
            endm1_reg  <= PPW'(EW'(found_reg) + EW'(len_reg) - 1'b1);
        end
        else if (cmd.eval)
        begin
            case (op_reg)
                OP_QUERY:
                begin
                    used_reg <= pos_ok_reg & rdata[pos_reg[BW-1:0]];
                end
                OP_ALLOC1:
                begin
                    if (fmask != '0)
                    begin
                        found_reg <= PPW'({addr_reg[AW-1:0], enc});
                        stat_reg  <= 1'b0;
                    end
                end
                OP_COUNT:
                begin
                    cnt_reg <= cnt_reg + PPW'(pcnt);
                end
                OP_ALLOCRUN:
                begin
                    if (fmask == ONES)
                    begin
                        if (run_reg == '0)
                        begin
                            start_reg <= word_pos;
                        end
                        run_reg <= run_reg + PPW'(W);
                        if ((EW'(run_reg) + EW'(W)) >= EW'(len_reg))
                        begin
                            found_reg <= (run_reg == '0) ? word_pos : start_reg;
                            stat_reg  <= 1'b0;
                        end
                    end
                    else if (fmask == '0)
                    begin
                        run_reg <= '0;
                    end
                end
                default:
                begin
                    used_reg <= used_reg;
                end
            endcase
        end
        else if (cmd.bstep)
        begin
            bptr_reg <= bptr_reg + 1'b1;
            if (fmask[bptr_reg])
            begin
                if (run_reg == '0)
                begin
                    start_reg <= cur_pos;
                end
                run_reg <= run_reg + 1'b1;
                if ((EW'(run_reg) + 1'b1) == EW'(len_reg))
                begin
                    found_reg <= (run_reg == '0) ? cur_pos : start_reg;
                    stat_reg  <= 1'b0;
                end
            end
            else
            begin
                run_reg <= '0;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.out)
        begin
            o_status_reg <= stat_reg;
            o_used_reg   <= used_reg;
            o_found_reg  <= 16'(EW'(found_reg));
            o_count_reg  <= 17'(EW'(cnt_reg));
        end
    end

    assign out_status      = o_status_reg;
    assign out_is_used     = o_used_reg;
    assign out_found_index = o_found_reg;
    assign out_free_count  = o_count_reg;

endmodule

// ===== rtl/bitmap_block_allocator_core.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator_core
// First-fit block allocator over a one-bit-per-block used map held in RAM.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over every map word before it
// takes its first item; the block limit register may be written meanwhile.
// One item is worked at a time over the map RAM, and every map word is read
// and then evaluated. Query and mark touch one word. Alloc one scans up to
// the first free block and count scans every word, both within the scan
// limit. Alloc run skips whole free or whole used words, but walks a partly
// used word one bit per cycle, then marks the run word by word. Mark run
// reads and rewrites each word it touches.
// A finished result sits in an output register, so the next item is accepted
// while it waits.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_core
    import bba_pkg::*;
#(
    parameter int BLOCKS    = DEF_BLOCKS,
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    bba_req_if.sink     req,
    bba_rsp_if.source   rsp,
    input  logic        cfg_we,
    input  logic [16:0] cfg_wdata
);

    cmd_t  cmd;
    stat_t st;

    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .st        (st),
        .cmd       (cmd)
    );

    bba_dp #(.BLOCKS(BLOCKS), .WORD_BITS(WORD_BITS)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .st              (st),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_op           (req.op),
        .in_block_index  (req.block_index),
        .in_run_length   (req.run_length),
        .in_mark_used    (req.mark_used),
        .out_status      (rsp.status),
        .out_is_used     (rsp.is_used),
        .out_found_index (rsp.found_index),
        .out_free_count  (rsp.free_count)
    );

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Regression bench for bitmap_block_allocator_core. Streams queries, marks,
// allocations and free counts under several block limit settings with
// random sender bursts and receiver stalls. Every result is checked against
// a shadow used map kept in the bench.
// ----------------------------------------------------------------------------
module tb_top
    import bba_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAP_BLOCKS  = DEF_BLOCKS;
    localparam int          STALL_LIMIT = 200000;
    localparam int          SETTLE      = 40;
    localparam logic [2:0]  OP_RSVD6    = 3'd6;
    localparam logic [2:0]  OP_RSVD7    = 3'd7;

    typedef struct {
        logic [2:0]  op;
        logic [15:0] block_index;
        logic [16:0] run_length;
        logic        mark_used;
    } alloc_req_t;

    typedef struct {
        logic        status;
        logic        is_used;
        logic [15:0] found_index;
        logic [16:0] free_count;
    } alloc_rsp_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [16:0] cfg_wdata;

    bba_req_if req_ch ();
    bba_rsp_if rsp_ch ();

    bitmap_block_allocator_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // shadow state
    bit          shadow_map [0:MAP_BLOCKS-1];
    int unsigned shadow_total;

    alloc_req_t  pending_reqs [$];
    alloc_rsp_t  expected_rsps [$];
    int          mismatch_cnt;
    int          hold_seq;

    // ------------------------------------------------------------------------
    // Shadow allocator
    // ------------------------------------------------------------------------
    function automatic int unsigned scan_end();
        return (shadow_total < MAP_BLOCKS) ? shadow_total : MAP_BLOCKS;
    endfunction

    function automatic void set_block(int unsigned pos, bit val);
        if (pos < MAP_BLOCKS)
            shadow_map[pos] = val;
    endfunction

    function automatic alloc_rsp_t apply_request(alloc_req_t r);
        alloc_rsp_t  res;
        int unsigned lim;
        int unsigned run;
        int unsigned start;
        lim = scan_end();
        res = '{status: 1'b0, is_used: 1'b0, found_index: '0, free_count: '0};
        run = 0;
        start = 0;
        case (r.op)
            OP_QUERY:
                res.is_used = shadow_map[r.block_index];
            OP_MARK:
                shadow_map[r.block_index] = r.mark_used;
            OP_ALLOC1:
            begin
                res.status = 1'b1;
                for (int unsigned i = 0; i < lim; i++)
                begin
                    if (!shadow_map[i])
                    begin
                        shadow_map[i] = 1'b1;
                        res.found_index = i[15:0];
                        res.status = 1'b0;
                        break;
                    end
                end
            end
            OP_ALLOCRUN:
            begin
                res.status = 1'b1;
                if (r.run_length != 0)
                begin
                    for (int unsigned i = 0; i < lim; i++)
                    begin
                        if (!shadow_map[i])
                        begin
                            if (run == 0)
                                start = i;
                            run++;
                            if (run == r.run_length)
                            begin
                                for (int unsigned j = 0; j < run; j++)
                                    set_block(start + j, 1'b1);
                                res.found_index = start[15:0];
                                res.status = 1'b0;
                                break;
                            end
                        end
                        else
                            run = 0;
                    end
                end
            end
            OP_MARKRUN:
                for (int unsigned j = 0; j < r.run_length; j++)
                    set_block(r.block_index + j, r.mark_used);
            OP_COUNT:
                for (int unsigned i = 0; i < lim; i++)
                    if (!shadow_map[i])
                        res.free_count++;
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Driver: bursts of items with random gaps
    // ------------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        alloc_req_t nxt;
        logic       nv;
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            burst_left   <= 4;
            gap_left     <= 0;
        end
        else
        begin
            nv = 1'b0;
            nxt = '{op: OP_QUERY, block_index: '0, run_length: '0, mark_used: 1'b0};
            if (req_ch.valid && req_ch.ready)
                expected_rsps.push_back(apply_request(pending_reqs.pop_front()));
            if (req_ch.valid && !req_ch.ready)
                nv = 1'b1;
            else if (gap_left > 0)
                gap_left <= gap_left - 1;
            else if (pending_reqs.size() > 0)
            begin
                nv = 1'b1;
                nxt = pending_reqs[0];
                req_ch.op          <= nxt.op;
                req_ch.block_index <= nxt.block_index;
                req_ch.run_length  <= nxt.run_length;
                req_ch.mark_used   <= nxt.mark_used;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                else
                    burst_left <= burst_left - 1;
            end
            req_ch.valid <= nv;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: receiver stall pattern, long hold-off, result check
    // ------------------------------------------------------------------------
    int ready_mode;
    int mode_left;
    int hold_left;
    int hold_seen;

    always @(posedge clk or negedge rst_n)
    begin
        alloc_rsp_t exp_rsp;
        logic       rdy;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            ready_mode   <= 0;
            mode_left    <= 0;
            hold_left    <= 0;
            hold_seen    <= 0;
        end
        else
        begin
            // check the item taken at this edge
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result: status=%0b used=%0b idx=%0d cnt=%0d",
                                 rsp_ch.status, rsp_ch.is_used, rsp_ch.found_index,
                                 rsp_ch.free_count);
                end
                else
                begin
                    exp_rsp = expected_rsps.pop_front();
                    if (rsp_ch.status !== exp_rsp.status || rsp_ch.is_used !== exp_rsp.is_used
                        || rsp_ch.found_index !== exp_rsp.found_index
                        || rsp_ch.free_count !== exp_rsp.free_count)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("%0t mismatch exp %0b/%0b/%0d/%0d got %0b/%0b/%0d/%0d",
                                     $realtime, exp_rsp.status, exp_rsp.is_used,
                                     exp_rsp.found_index, exp_rsp.free_count,
                                     rsp_ch.status, rsp_ch.is_used,
                                     rsp_ch.found_index, rsp_ch.free_count);
                    end
                end
            end

            // ready pattern
            if (hold_seq != hold_seen)
            begin
                hold_seen <= hold_seq;
                hold_left <= 600;
                rdy = 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                rdy = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    ready_mode <= $urandom_range(0, 2);
                    mode_left  <= $urandom_range(8, 80);
                end
                else
                    mode_left <= mode_left - 1;
                case (ready_mode)
                    0:       rdy = 1'b1;
                    1:       rdy = $urandom_range(0, 1);
                    default: rdy = ($urandom_range(0, 4) == 0);
                endcase
            end
            rsp_ch.ready <= rdy;
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: cycles with work outstanding and nothing accepted
    // ------------------------------------------------------------------------
    int idle_cycles;

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (pending_reqs.size() == 0 && expected_rsps.size() == 0))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("bitmap_block_allocator_core regression: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic alloc_req_t make_req(logic [2:0] op, int unsigned idx,
                                            int unsigned len, bit mark);
        alloc_req_t r;
        r.op          = op;
        r.block_index = idx[15:0];
        r.run_length  = len[16:0];
        r.mark_used   = mark;
        return r;
    endfunction

    function automatic alloc_req_t random_req();
        alloc_req_t  r;
        int unsigned sel;
        int unsigned span;
        span = scan_end() + 70;
        if (span > 65535)
            span = 65535;
        sel = $urandom_range(0, 99);
        if (sel < 15)      r.op = OP_QUERY;
        else if (sel < 35) r.op = OP_MARK;
        else if (sel < 55) r.op = OP_ALLOC1;
        else if (sel < 75) r.op = OP_ALLOCRUN;
        else if (sel < 90) r.op = OP_MARKRUN;
        else if (sel < 97) r.op = OP_COUNT;
        else               r.op = $urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7;
        r.block_index = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, span))
                                                     : 16'($urandom());
        sel = $urandom_range(0, 99);
        if (sel < 88)      r.run_length = 17'($urandom_range(0, 80));
        else if (sel < 96) r.run_length = 17'($urandom_range(0, span));
        else               r.run_length = 17'($urandom());
        // lean toward freeing so the map does not just fill up
        r.mark_used = ($urandom_range(0, 99) < 45);
        return r;
    endfunction

    task automatic drain();
        while (pending_reqs.size() != 0 || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_total(int unsigned val);
        cfg_we    <= 1'b1;
        cfg_wdata <= val[16:0];
        @(posedge clk);
        cfg_we    <= 1'b0;
        shadow_total = val & 17'h1FFFF;
    endtask

    task automatic random_phase(int unsigned total, int n, bit with_hold);
        drain();
        write_total(total);
        for (int k = 0; k < n; k++)
            pending_reqs.push_back(random_req());
        if (with_hold)
            hold_seq++;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        req_ch.valid = 1'b0;
        req_ch.op    = OP_QUERY;
        req_ch.block_index = '0;
        req_ch.run_length  = '0;
        req_ch.mark_used   = 1'b0;
        mismatch_cnt = 0;
        hold_seq     = 0;
        idle_cycles  = 0;
        shadow_total = BLK_LIMIT_RST;
        foreach (shadow_map[i])
            shadow_map[i] = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: edges of every field, full map, runs past the map
        pending_reqs.push_back(make_req(OP_COUNT,    0,     0,     0));
        pending_reqs.push_back(make_req(OP_ALLOC1,   0,     0,     0));
        pending_reqs.push_back(make_req(OP_QUERY,    0,     0,     0));
        pending_reqs.push_back(make_req(OP_QUERY,    65535, 0,     1));
        pending_reqs.push_back(make_req(OP_MARK,     65535, 0,     1));
        pending_reqs.push_back(make_req(OP_QUERY,    65535, 0,     0));
        pending_reqs.push_back(make_req(OP_MARKRUN,  65530, 20,    1));
        pending_reqs.push_back(make_req(OP_QUERY,    65534, 0,     0));
        pending_reqs.push_back(make_req(OP_COUNT,    0,     0,     0));
        pending_reqs.push_back(make_req(OP_ALLOCRUN, 0,     0,     0));
        pending_reqs.push_back(make_req(OP_ALLOCRUN, 0,     65536, 0));
        pending_reqs.push_back(make_req(OP_ALLOCRUN, 0,     100,   0));
        pending_reqs.push_back(make_req(OP_MARKRUN,  0,     65536, 0));
        pending_reqs.push_back(make_req(OP_ALLOCRUN, 0,     65536, 0));
        pending_reqs.push_back(make_req(OP_ALLOC1,   0,     0,     0));
        pending_reqs.push_back(make_req(OP_COUNT,    0,     0,     0));
        pending_reqs.push_back(make_req(OP_MARKRUN,  0,     131071, 0));
        pending_reqs.push_back(make_req(OP_RSVD6,    65535, 131071, 1));
        pending_reqs.push_back(make_req(OP_RSVD7,    43690, 87381, 1));
        pending_reqs.push_back(make_req(OP_MARK,     21845, 0,     1));
        pending_reqs.push_back(make_req(OP_QUERY,    21845, 0,     0));
        pending_reqs.push_back(make_req(OP_QUERY,    43690, 0,     0));
        pending_reqs.push_back(make_req(OP_ALLOC1,   0,     0,     0));

        // random phases over several scan limits, extremes included
        random_phase(0,      40,  1'b0);
        random_phase(1,      40,  1'b0);
        random_phase(100,    120, 1'b0);
        random_phase(256,    150, 1'b1);
        random_phase(131071, 20,  1'b0);
        random_phase(70,     120, 1'b0);
        random_phase(200,    90,  1'b0);
        drain();

        if (mismatch_cnt == 0 && expected_rsps.size() == 0)
            $display("bitmap_block_allocator_core regression: pass");
        else
            $display("bitmap_block_allocator_core regression: fail");
        $finish;
    end

endmodule
